[hw/rtl/brf_pkg.sv]
// Package for the byte ring FIFO: request and result beat types, codes, defaults.
// No dependencies; imported by every module of the block.
`default_nettype none

package brf_pkg;

  // default number of slots in the ring
  localparam int DefDepth = 256;

  // requested operation
  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_e;

  // result status
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FULL_DROPPED = 3'd1,
    ST_OVERWRITTEN  = 3'd2,
    ST_EMPTY        = 3'd3,
    ST_OFFSET_RANGE = 3'd4
  } status_e;

  // request beat
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_in;
    logic [7:0] peek_offset;
  } req_t;

  // result beat
  typedef struct packed {
    logic [7:0] data_out;
    status_e    status;
    logic [7:0] fill_level;
    logic [7:0] free_space;
  } res_t;

  // registered result info from the pointer control, minus the read byte
  typedef struct packed {
    logic       data_sel;
    status_e    status;
    logic [7:0] fill_level;
    logic [7:0] free_space;
  } res_info_t;

endpackage

`default_nettype wire

[hw/rtl/brf_mem.sv]
// Slot storage of the byte ring FIFO: one write port, one registered read port.
// Depends on brf_pkg for the default depth.
`default_nettype none

module brf_mem
  import brf_pkg::*;
#(
  parameter int Depth = DefDepth,
  parameter int AW    = $clog2(Depth)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] slot_q [Depth];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      slot_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= slot_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/brf_ctrl.sv]
// Head/tail pointer control of the byte ring FIFO: decodes a request beat,
// drives the slot memory and registers status and levels. Depends on brf_pkg.
`default_nettype none

module brf_ctrl
  import brf_pkg::*;
#(
  parameter int Depth = DefDepth,
  parameter int AW    = $clog2(Depth)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire req_t          req_i,
  input  wire logic          ovw_i,
  output logic               mem_we_o,
  output logic      [AW-1:0] mem_waddr_o,
  output logic      [7:0]    mem_wdata_o,
  output logic               mem_re_o,
  output logic      [AW-1:0] mem_raddr_o,
  output logic               valid_o,
  output res_info_t          info_o
);

  // wide enough for the depth itself and for tail plus an 8-bit offset
  localparam int SW = ((AW > 8) ? AW : 8) + 1;
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic          valid_q;
  res_info_t     info_q, info_d;

  logic [AW-1:0] fill;
  logic [AW-1:0] fill_after;
  logic [AW-1:0] free_after;
  logic [AW-1:0] head_nxt;
  logic [AW-1:0] tail_nxt;
  logic          full;
  logic          empty;
  logic [SW-1:0] peek_sum;
  logic [SW-1:0] peek_wrap;
  logic          peek_bad;
  logic [SW-1:0] fill_w;
  logic [SW-1:0] free_w;

  // current fill level and ring increments
  always_comb begin
    if (head_q >= tail_q) begin
      fill = head_q - tail_q;
    end else begin
      fill = AW'(SW'(Depth) - SW'(tail_q) + SW'(head_q));
    end
    head_nxt = (head_q == LastIdx) ? '0 : head_q + AW'(1);
    tail_nxt = (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
    full     = (head_nxt == tail_q);
    empty    = (fill == '0);
  end

  // peek address, one wrap at most for an offset below the fill level
  always_comb begin
    peek_sum  = SW'(tail_q) + SW'(req_i.peek_offset);
    peek_wrap = (peek_sum >= SW'(Depth)) ? (peek_sum - SW'(Depth)) : peek_sum;
    peek_bad  = (SW'(req_i.peek_offset) >= SW'(fill));
  end

  // request decode
  always_comb begin
    head_d         = head_q;
    tail_d         = tail_q;
    fill_after     = fill;
    mem_we_o       = 1'b0;
    mem_waddr_o    = head_q;
    mem_wdata_o    = req_i.data_in;
    mem_re_o       = 1'b0;
    mem_raddr_o    = tail_q;
    info_d         = '0;
    info_d.status  = ST_OK;
    unique case (req_i.kind)
      KIND_PUSH: begin
        if (full && !ovw_i) begin
          info_d.status = ST_FULL_DROPPED;
        end else begin
          mem_we_o = accept_i;
          head_d   = head_nxt;
          if (full) begin
            tail_d        = tail_nxt;
            info_d.status = ST_OVERWRITTEN;
          end else begin
            fill_after = fill + AW'(1);
          end
        end
      end
      KIND_POP: begin
        if (empty) begin
          info_d.status = ST_EMPTY;
        end else begin
          mem_re_o        = accept_i;
          info_d.data_sel = 1'b1;
          tail_d          = tail_nxt;
          fill_after      = fill - AW'(1);
        end
      end
      KIND_PEEK: begin
        if (peek_bad) begin
          info_d.status = ST_OFFSET_RANGE;
        end else begin
          mem_re_o        = accept_i;
          mem_raddr_o     = peek_wrap[AW-1:0];
          info_d.data_sel = 1'b1;
        end
      end
      default: begin
        // unused kind: no operation
      end
    endcase
    free_after        = LastIdx - fill_after;
    fill_w            = SW'(fill_after);
    free_w            = SW'(free_after);
    info_d.fill_level = fill_w[7:0];
    info_d.free_space = free_w[7:0];
  end

  // pointers and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
      if (accept_i) begin
        head_q <= head_d;
        tail_q <= tail_d;
      end
    end
  end

  // result info register
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      info_q <= info_d;
    end
  end

  assign valid_o = valid_q;
  assign info_o  = info_q;

endmodule

`default_nettype wire

[hw/rtl/byte_ring_fifo_overwrite_peek_top.sv]
// Top level of the byte ring FIFO with overwrite option and peek.
// Depends on brf_pkg, brf_ctrl and brf_mem.
//
// A request beat is taken on every cycle that start is high; busy stays low,
// so one push, pop or peek enters per clock. Its result comes out exactly one
// cycle later, on the cycle after the accepting edge, marked by res_valid_o
// for that single cycle: the latency is set by the registered read of the
// slot memory, and the receiver must take it then, it cannot stall the block.
// The ring keeps one slot empty and holds at most Depth-1 bytes. The overwrite
// register may be written through the cfg channel whenever no result is
// pending; cfg_ready_o is always high.
`default_nettype none

module byte_ring_fifo_overwrite_peek_top
  import brf_pkg::*;
#(
  parameter int Depth = DefDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      res_valid_o,
  output res_t      res_o,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic cfg_data_i
);

  localparam int AW = $clog2(Depth);

  logic          accept;
  logic          ovw_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          res_valid;
  res_info_t     info;

  // a beat enters on every cycle that start is high
  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // overwrite-when-full register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovw_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ovw_q <= cfg_data_i;
    end
  end

  brf_ctrl #(
    .Depth (Depth),
    .AW    (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .ovw_i       (ovw_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .valid_o     (res_valid),
    .info_o      (info)
  );

  brf_mem #(
    .Depth (Depth),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // result beat assembly
  always_comb begin
    res_o.data_out   = info.data_sel ? mem_rdata : 8'h00;
    res_o.status     = info.status;
    res_o.fill_level = info.fill_level;
    res_o.free_space = info.free_space;
  end

  assign res_valid_o = res_valid;

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking bench for the byte ring FIFO top: directed corner beats, then random traffic.
// Depends on brf_pkg and byte_ring_fifo_overwrite_peek_top; a local ring model predicts each result.
`default_nettype none

module tb;
  import brf_pkg::*;

  localparam int RING_SLOTS = DefDepth;
  localparam int HALF_PERIOD = 4;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;

  // ring model state
  logic [7:0] ring_mem [RING_SLOTS];
  int         wr_idx = 0;
  int         rd_idx = 0;
  bit         ow_mode = 1'b0;

  // result beats still to come, oldest first
  res_t       due_results[$];

  bit         idle_on = 1'b1;
  int         err_count = 0;
  int         n_accepted = 0;
  int         n_overwr = 0;
  int         n_dropped = 0;
  int         n_empty = 0;
  int         n_range = 0;
  int         n_read_hit = 0;

  byte_ring_fifo_overwrite_peek_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // hard stop if the run hangs
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  // bytes currently held by the model
  function automatic int held_count();
    if (wr_idx >= rd_idx) return wr_idx - rd_idx;
    return RING_SLOTS - rd_idx + wr_idx;
  endfunction

  // apply one request beat to the model, return the result beat it causes
  function automatic res_t fifo_apply(input req_t r);
    res_t o;
    int   nxt;
    int   lvl;
    o = '0;
    o.status = ST_OK;
    lvl = held_count();
    case (r.kind)
      KIND_PUSH: begin
        nxt = (wr_idx + 1) % RING_SLOTS;
        if (nxt == rd_idx && !ow_mode) begin
          o.status = ST_FULL_DROPPED;
        end else begin
          // full with overwrite on: oldest byte goes first
          if (nxt == rd_idx) begin
            rd_idx = (rd_idx + 1) % RING_SLOTS;
            o.status = ST_OVERWRITTEN;
          end
          ring_mem[wr_idx] = r.data_in;
          wr_idx = nxt;
        end
      end
      KIND_POP: begin
        if (lvl == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.data_out = ring_mem[rd_idx];
          rd_idx = (rd_idx + 1) % RING_SLOTS;
        end
      end
      KIND_PEEK: begin
        if (int'(r.peek_offset) >= lvl) begin
          o.status = ST_OFFSET_RANGE;
        end else begin
          o.data_out = ring_mem[(rd_idx + int'(r.peek_offset)) % RING_SLOTS];
        end
      end
      default: begin
        // unused kind: no change
      end
    endcase
    lvl = held_count();
    o.fill_level = 8'(lvl);
    o.free_space = 8'(RING_SLOTS - 1 - lvl);
    return o;
  endfunction

  // result check, register tracking and prediction on every rising edge
  always @(posedge clk_i) begin : mon
    res_t want;
    res_t got;
    if (rst_ni) begin
      if (res_valid_o === 1'b1) begin
        got = res_o;
        if (due_results.size() == 0) begin
          $error("unexpected result beat: data_out %0d status %0d", got.data_out, got.status);
          err_count++;
        end else begin
          want = due_results.pop_front();
          if (got.data_out !== want.data_out) begin
            $error("data_out: expected %0d, actual %0d", want.data_out, got.data_out);
            err_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            err_count++;
          end
          if (got.fill_level !== want.fill_level) begin
            $error("fill_level: expected %0d, actual %0d", want.fill_level, got.fill_level);
            err_count++;
          end
          if (got.free_space !== want.free_space) begin
            $error("free_space: expected %0d, actual %0d", want.free_space, got.free_space);
            err_count++;
          end
        end
      end
      if (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1) begin
        ow_mode = cfg_data_i;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want = fifo_apply(req_i);
        due_results.push_back(want);
        n_accepted++;
        case (want.status)
          ST_OVERWRITTEN:  n_overwr++;
          ST_FULL_DROPPED: n_dropped++;
          ST_EMPTY:        n_empty++;
          ST_OFFSET_RANGE: n_range++;
          default: begin
            if (req_i.kind == KIND_POP || req_i.kind == KIND_PEEK) n_read_hit++;
          end
        endcase
      end
    end
  end

  // send one request beat; entered and left at a falling edge
  task automatic send_req(input logic [1:0] k, input logic [7:0] d, input logic [7:0] off);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    req_i.kind = kind_e'(k);
    req_i.data_in = d;
    req_i.peek_offset = off;
    do @(posedge clk_i); while (busy !== 1'b0);
    @(negedge clk_i);
  endtask

  // stop issuing and let every pending result come out
  task automatic wait_idle();
    start = 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // write the overwrite register while idle
  task automatic write_overwrite(input bit v);
    wait_idle();
    cfg_valid_i = 1'b1;
    cfg_data_i = v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // errors and the unused kind right after reset, then a short fill and drain
  task automatic test_empty_and_noop();
    idle_on = 1'b1;
    send_req(KIND_POP, 8'h5a, 8'h00);
    send_req(KIND_PEEK, 8'h00, 8'h00);
    send_req(KIND_PEEK, 8'hff, 8'hff);
    send_req(2'd3, 8'hff, 8'hff);
    send_req(KIND_PUSH, 8'h00, 8'hff);
    send_req(KIND_PUSH, 8'hff, 8'h00);
    send_req(KIND_PEEK, 8'h11, 8'h00);
    send_req(KIND_PEEK, 8'h22, 8'h01);
    send_req(KIND_PEEK, 8'h33, 8'h02);
    send_req(KIND_PEEK, 8'h44, 8'hff);
    send_req(KIND_POP, 8'h00, 8'h00);
    send_req(KIND_POP, 8'hff, 8'hff);
    send_req(KIND_POP, 8'h00, 8'h00);
    send_req(KIND_PUSH, 8'ha5, 8'h5a);
    send_req(2'd3, 8'h00, 8'h00);
    send_req(KIND_POP, 8'h00, 8'h00);
  endtask

  // fill to the limit with overwrite off, pushes past it are dropped
  task automatic test_fill_and_drop();
    write_overwrite(1'b0);
    idle_on = 1'b0;
    while (held_count() < RING_SLOTS - 1) begin
      send_req(KIND_PUSH, 8'($urandom), 8'($urandom));
    end
    idle_on = 1'b1;
    repeat (3) send_req(KIND_PUSH, 8'($urandom), 8'($urandom));
    send_req(KIND_PEEK, 8'h00, 8'(RING_SLOTS - 2));
    send_req(KIND_PEEK, 8'h00, 8'hff);
    send_req(KIND_PEEK, 8'h00, 8'h00);
    send_req(KIND_POP, 8'h00, 8'h00);
    send_req(KIND_PUSH, 8'h7e, 8'h00);
    send_req(KIND_PUSH, 8'h81, 8'h00);
  endtask

  // overwrite on while full, then drain down past empty
  task automatic test_overwrite_and_drain();
    write_overwrite(1'b1);
    idle_on = 1'b1;
    repeat (20) send_req(KIND_PUSH, 8'($urandom), 8'($urandom));
    send_req(KIND_PEEK, 8'h00, 8'h00);
    send_req(KIND_PEEK, 8'h00, 8'h80);
    send_req(KIND_PEEK, 8'h00, 8'(RING_SLOTS - 2));
    send_req(KIND_PEEK, 8'h00, 8'hff);
    while (held_count() > 0) begin
      send_req(KIND_POP, 8'($urandom), 8'($urandom));
    end
    send_req(KIND_POP, 8'h00, 8'h00);
    send_req(KIND_PUSH, 8'($urandom), 8'h00);
  endtask

  // bursts biased toward filling, draining or mixing, register toggled per phase
  task automatic test_random_traffic();
    int mode;
    int burst;
    int pick;
    int lvl;
    int sent;
    logic [1:0] k;
    logic [7:0] off;
    for (int phase = 0; phase < 4; phase++) begin
      write_overwrite(phase[0]);
      sent = 0;
      while (sent < 50) begin
        mode = $urandom_range(0, 2);
        burst = $urandom_range(10, 30);
        idle_on = $urandom_range(0, 1);
        repeat (burst) begin
          pick = $urandom_range(0, 99);
          case (mode)
            0: k = (pick < 75) ? KIND_PUSH : (pick < 88) ? KIND_POP :
                   (pick < 97) ? KIND_PEEK : 2'd3;
            1: k = (pick < 20) ? KIND_PUSH : (pick < 85) ? KIND_POP :
                   (pick < 97) ? KIND_PEEK : 2'd3;
            default: k = (pick < 40) ? KIND_PUSH : (pick < 70) ? KIND_POP :
                         (pick < 97) ? KIND_PEEK : 2'd3;
          endcase
          // peek offsets mostly at or below the current level
          lvl = held_count();
          if ($urandom_range(0, 9) < 7) off = 8'($urandom_range(0, lvl));
          else off = 8'($urandom);
          send_req(k, 8'($urandom), off);
          sent++;
        end
      end
    end
  endtask

  // reset, test sequence and verdict
  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_and_noop();
    test_fill_and_drop();
    test_overwrite_and_drain();
    test_random_traffic();

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("run covered %0d request beats, %0d pops or peeks that returned a byte",
             n_accepted, n_read_hit);
    $display("corner outcomes: %0d overwrites, %0d dropped pushes, %0d empty pops, %0d bad offsets",
             n_overwr, n_dropped, n_empty, n_range);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
